[rtl/rtpjb_pkg.sv]
// ----------------------------------------------------------------------------
// rtpjb_pkg: shared constants for the jitter reorder buffer
// Widths, modes, insert status codes, register addresses and register defaults.
// ----------------------------------------------------------------------------
package rtpjb_pkg;

   localparam int SLOTS_DEF     = 64;
   localparam int EXT_WIDTH_DEF = 48;
   localparam int SEQ_W         = 16;
   localparam int CFG_W         = 7;
   localparam int CNT_W         = 32;

   localparam logic [CFG_W-1:0] CAP_RESET    = 7'd64;
   localparam logic [CFG_W-1:0] TARGET_RESET = 7'd8;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_FLUSH  = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_LATE     = 2'd1;
   localparam logic [1:0] ST_DUP      = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   localparam logic [0:0] REG_CAPACITY = 1'd0;
   localparam logic [0:0] REG_TARGET   = 1'd1;

endpackage

[rtl/rtp_jitter_reorder_buffer.sv]
// ----------------------------------------------------------------------------
// rtp_jitter_reorder_buffer
// Sequence-number reorder buffer with a slot table scanned by one comparator.
// ----------------------------------------------------------------------------
//  channel | ports                              | handshake
//  request | start, busy, req_*                 | taken when start && !busy
//  result  | rsp_strobe, rsp_*                  | one cycle, cannot stall
//  config  | csr_psel/penable/pwrite/paddr/...  | APB, pready always high
//
// Steps (busy after the accepting edge): an accepted insert runs unwrap, one
// table scan for duplicate and fill count, decide, capacity check, place, done,
// plus a drop scan per drop; rejected: unwrap, scan, decide, done; a tick scan,
// check, done, or done if unstarted; a flush flush, done; a no-op done.
// The slot table is read one entry a cycle through a single registered read
// port and compared by one shared comparator. The result strobes in the cycle
// after, with busy already low. Reset is synchronous; the receiver cannot
// stall, so results leave at once.
module rtp_jitter_reorder_buffer #(
   parameter int SLOTS     = rtpjb_pkg::SLOTS_DEF,
   parameter int EXT_WIDTH = rtpjb_pkg::EXT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_packet_seq,
   input  logic [31:0] req_packet_payload,
   output logic        rsp_strobe,
   output logic        rsp_packet_valid,
   output logic [15:0] rsp_out_seq,
   output logic [31:0] rsp_out_payload,
   output logic        rsp_lost_flag,
   output logic [1:0]  rsp_insert_status,
   output logic        rsp_reordered_flag,
   output logic        rsp_overflow_flag,
   output logic [31:0] rsp_received_count,
   output logic [31:0] rsp_discarded_count,
   output logic [31:0] rsp_reordered_count,
   output logic [31:0] rsp_dropped_count,
   output logic [31:0] rsp_lost_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   // compare width for fill vs. register values
   localparam int KW = ((CW > rtpjb_pkg::CFG_W) ? CW : rtpjb_pkg::CFG_W) + 1;
   localparam logic [EXT_WIDTH-1:0] SIGN = {1'b1, {(EXT_WIDTH-1){1'b0}}};
   localparam logic [EXT_WIDTH-1:0] ONE  = EXT_WIDTH'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_UNWRAP, S_DUPSCAN, S_DECIDE, S_DROPSCAN, S_DROPDONE,
      S_PLACE, S_TICKSCAN, S_TICKDONE, S_FLUSH, S_DONE
   } state_type;

   state_type state_ff;

   // slot table: used bits in flops, ext/payload in memory
   logic [SLOTS-1:0]     used_ff;
   logic [EXT_WIDTH-1:0] mem_ext [SLOTS];
   logic [31:0]          mem_pay [SLOTS];
   logic [EXT_WIDTH-1:0] rd_ext_ff;
   logic [31:0]          rd_pay_ff;
   logic                 rd_used_ff;
   logic [IW-1:0]        rd_idx_ff;
   logic                 rd_vld_ff;

   logic [6:0] cap_ff, target_ff;
   logic started_ff, primed_ff;
   logic [EXT_WIDTH-1:0] highest_ff, playout_ff, ext_ff, oext_ff;
   logic [15:0] oseq_ff;        // latched request sequence
   logic [31:0] pay_ff;
   logic [CW-1:0] count_ff;
   logic [IW:0]   scan_ff;      // issue pointer, SLOTS means done issuing
   logic          found_ff, pending_ff, have_old_ff;
   logic [IW-1:0] hit_ff, old_ff;
   logic [31:0] c_rx_ff, c_disc_ff, c_reo_ff, c_drop_ff, c_lost_ff;
   logic [1:0]  status_ff;
   logic        reo_ff, ovf_ff, pv_ff, lost_ff, strobe_ff;
   logic [15:0] oseq_out_ff;
   logic [31:0] opay_ff;
   logic [IW-1:0] free_ff;
   logic          free_found_ff;

   function automatic logic less(input logic [EXT_WIDTH-1:0] a,
                                 input logic [EXT_WIDTH-1:0] b);
      return (a ^ SIGN) < (b ^ SIGN);
   endfunction

   // unwrap against highest
   logic [15:0] low, d;
   logic [EXT_WIDTH-1:0] unwrapped;
   always_comb begin
      low = highest_ff[15:0];
      d   = oseq_ff - low;
      if (d < 16'd32768 || (d == 16'd32768 && oseq_ff > low))
         unwrapped = highest_ff + EXT_WIDTH'(d);
      else
         unwrapped = highest_ff + EXT_WIDTH'(d) - EXT_WIDTH'(17'd65536);
   end

   logic [KW-1:0] cap_eff;
   assign cap_eff = (KW'(cap_ff) > KW'(SLOTS)) ? KW'(SLOTS) : KW'(cap_ff);

   wire issue = (scan_ff < (IW+1)'(SLOTS));
   wire cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign busy       = (state_ff != S_IDLE);
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         rtpjb_pkg::REG_CAPACITY: csr_prdata = {25'd0, cap_ff};
         rtpjb_pkg::REG_TARGET:   csr_prdata = {25'd0, target_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_packet_valid    = pv_ff;
   assign rsp_out_seq         = oseq_out_ff;
   assign rsp_out_payload     = opay_ff;
   assign rsp_lost_flag       = lost_ff;
   assign rsp_insert_status   = status_ff;
   assign rsp_reordered_flag  = reo_ff;
   assign rsp_overflow_flag   = ovf_ff;
   assign rsp_received_count  = c_rx_ff;
   assign rsp_discarded_count = c_disc_ff;
   assign rsp_reordered_count = c_reo_ff;
   assign rsp_dropped_count   = c_drop_ff;
   assign rsp_lost_count      = c_lost_ff;

   // memory write port
   logic mem_we;
   logic [IW-1:0] mem_wa;
   assign mem_we = (state_ff == S_PLACE) && pending_ff && free_found_ff;
   assign mem_wa = free_ff;
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ext[mem_wa] <= ext_ff;
         mem_pay[mem_wa] <= pay_ff;
      end
      rd_ext_ff  <= mem_ext[scan_ff[IW-1:0]];
      rd_pay_ff  <= mem_pay[scan_ff[IW-1:0]];
      rd_used_ff <= used_ff[scan_ff[IW-1:0]];
      rd_idx_ff  <= scan_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff <= rtpjb_pkg::CAP_RESET;
         target_ff <= rtpjb_pkg::TARGET_RESET;
         used_ff <= '0;
         started_ff <= 1'b0; primed_ff <= 1'b0;
         highest_ff <= '0; playout_ff <= '0;
         c_rx_ff <= '0; c_disc_ff <= '0; c_reo_ff <= '0;
         c_drop_ff <= '0; c_lost_ff <= '0;
         strobe_ff <= 1'b0; rd_vld_ff <= 1'b0;
         scan_ff <= (IW+1)'(SLOTS);
         pv_ff <= 1'b0; lost_ff <= 1'b0; reo_ff <= 1'b0; ovf_ff <= 1'b0;
         status_ff <= rtpjb_pkg::ST_NONE;
         opay_ff <= '0; oseq_out_ff <= '0;
      end else begin
         strobe_ff <= (state_ff == S_DONE);
         rd_vld_ff <= issue;
         if (cfg_wr) begin
            unique case (csr_paddr[2])
               rtpjb_pkg::REG_CAPACITY: cap_ff <= csr_pwdata[6:0];
               rtpjb_pkg::REG_TARGET:   target_ff <= csr_pwdata[6:0];
               default: ;
            endcase
         end
         // scan pointer rests at SLOTS outside a scan
         if (issue && state_ff != S_IDLE) scan_ff <= scan_ff + 1'b1;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  oseq_ff <= req_packet_seq;
                  pay_ff <= req_packet_payload;
                  pv_ff <= 1'b0; lost_ff <= 1'b0; reo_ff <= 1'b0; ovf_ff <= 1'b0;
                  opay_ff <= '0; oseq_out_ff <= '0;
                  status_ff <= rtpjb_pkg::ST_NONE;
                  found_ff <= 1'b0; count_ff <= '0;
                  free_found_ff <= 1'b0;
                  unique case (req_mode)
                     rtpjb_pkg::MODE_INSERT: state_ff <= S_UNWRAP;
                     rtpjb_pkg::MODE_TICK: begin
                        if (!started_ff) state_ff <= S_DONE;
                        else begin
                           scan_ff <= '0;
                           state_ff <= S_TICKSCAN;
                        end
                     end
                     rtpjb_pkg::MODE_FLUSH: state_ff <= S_FLUSH;
                     rtpjb_pkg::MODE_NOP:   state_ff <= S_DONE;
                     default:               state_ff <= S_DONE;
                  endcase
               end
            end
            S_UNWRAP: begin
               if (!started_ff) begin
                  started_ff <= 1'b1;
                  ext_ff <= EXT_WIDTH'(oseq_ff);
                  highest_ff <= EXT_WIDTH'(oseq_ff);
                  playout_ff <= EXT_WIDTH'(oseq_ff);
               end else begin
                  ext_ff <= unwrapped;
               end
               scan_ff <= '0;
               state_ff <= S_DUPSCAN;
            end
            S_DUPSCAN: begin
               if (rd_vld_ff) begin
                  if (rd_used_ff) count_ff <= count_ff + 1'b1;
                  if (rd_used_ff && rd_ext_ff == ext_ff) found_ff <= 1'b1;
                  if (!rd_used_ff && !free_found_ff) begin
                     free_found_ff <= 1'b1; free_ff <= rd_idx_ff;
                  end
               end else if (!issue) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (less(ext_ff, playout_ff)) begin
                  c_disc_ff <= c_disc_ff + 1'b1; status_ff <= rtpjb_pkg::ST_LATE;
                  state_ff <= S_DONE;
               end else if (found_ff) begin
                  c_disc_ff <= c_disc_ff + 1'b1; status_ff <= rtpjb_pkg::ST_DUP;
                  state_ff <= S_DONE;
               end else begin
                  status_ff <= rtpjb_pkg::ST_ACCEPTED;
                  if (less(ext_ff, highest_ff)) begin
                     c_reo_ff <= c_reo_ff + 1'b1; reo_ff <= 1'b1;
                  end
                  if (less(highest_ff, ext_ff)) highest_ff <= ext_ff;
                  c_rx_ff <= c_rx_ff + 1'b1;
                  pending_ff <= 1'b1;
                  state_ff <= S_DROPDONE;
               end
            end
            S_DROPDONE: begin
               // check capacity; start a drop scan if over
               if (KW'(count_ff) + KW'(pending_ff) > cap_eff) begin
                  scan_ff <= '0; have_old_ff <= 1'b0; oext_ff <= ext_ff;
                  state_ff <= S_DROPSCAN;
               end else state_ff <= S_PLACE;
            end
            S_DROPSCAN: begin
               if (rd_vld_ff) begin
                  if (rd_used_ff) begin
                     if ((!have_old_ff && !pending_ff) || less(rd_ext_ff, oext_ff)) begin
                        have_old_ff <= 1'b1; old_ff <= rd_idx_ff; oext_ff <= rd_ext_ff;
                     end
                  end
               end else if (!issue) begin
                  if (!less(oext_ff, playout_ff)) playout_ff <= oext_ff + ONE;
                  if (!have_old_ff) pending_ff <= 1'b0;
                  else begin
                     used_ff[old_ff] <= 1'b0; count_ff <= count_ff - 1'b1;
                     if (!free_found_ff) begin
                        free_found_ff <= 1'b1; free_ff <= old_ff;
                     end
                  end
                  c_drop_ff <= c_drop_ff + 1'b1; ovf_ff <= 1'b1;
                  state_ff <= S_DROPDONE;
               end
            end
            S_PLACE: begin
               if (pending_ff && free_found_ff) used_ff[free_ff] <= 1'b1;
               state_ff <= S_DONE;
            end
            S_TICKSCAN: begin
               if (rd_vld_ff) begin
                  if (rd_used_ff) count_ff <= count_ff + 1'b1;
                  if (rd_used_ff && rd_ext_ff == playout_ff) begin
                     found_ff <= 1'b1; hit_ff <= rd_idx_ff;
                     oseq_out_ff <= rd_ext_ff[15:0]; opay_ff <= rd_pay_ff;
                  end
               end else if (!issue) state_ff <= S_TICKDONE;
            end
            S_TICKDONE: begin
               state_ff <= S_DONE;
               if (!primed_ff && (KW'(count_ff) < KW'(target_ff))) begin
                  oseq_out_ff <= '0; opay_ff <= '0;
               end else if (count_ff == '0) begin
                  primed_ff <= 1'b1; oseq_out_ff <= '0; opay_ff <= '0;
               end else begin
                  primed_ff <= 1'b1;
                  if (found_ff) begin
                     pv_ff <= 1'b1; used_ff[hit_ff] <= 1'b0;
                  end else begin
                     lost_ff <= 1'b1; c_lost_ff <= c_lost_ff + 1'b1;
                  end
                  playout_ff <= playout_ff + ONE;
               end
            end
            S_FLUSH: begin
               used_ff <= '0; started_ff <= 1'b0; primed_ff <= 1'b0;
               highest_ff <= '0; playout_ff <= '0;
               c_rx_ff <= '0; c_disc_ff <= '0; c_reo_ff <= '0;
               c_drop_ff <= '0; c_lost_ff <= '0;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
